// ===== hdl/lpr_pkg.sv =====
// package for the loop packet receiver: codes, result type, crc and trend helpers
package lpr_pkg;

    localparam int COUNT_W  = 7;
    localparam int NUM_CAPT = 18;
    localparam int SLOT_W   = 5;

    localparam logic [7:0]  ACK_BYTE  = 8'h06;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [COUNT_W-1:0] TREND_POS = 7'd4;

    // trend byte codes, read as signed: -60, -20, 0, 20, 60
    localparam logic [7:0] TREND_CODE_FALL_FAST = 8'hC4;
    localparam logic [7:0] TREND_CODE_FALL_SLOW = 8'hEC;
    localparam logic [7:0] TREND_CODE_STEADY    = 8'h00;
    localparam logic [7:0] TREND_CODE_RISE_SLOW = 8'h14;
    localparam logic [7:0] TREND_CODE_RISE_FAST = 8'h3C;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_NO_ACK  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        TREND_UNKNOWN   = 3'd0,
        TREND_FALL_FAST = 3'd1,
        TREND_FALL_SLOW = 3'd2,
        TREND_STEADY    = 3'd3,
        TREND_RISE_SLOW = 3'd4,
        TREND_RISE_FAST = 3'd5
    } trend_t;

    typedef struct packed {
        status_t            status;
        trend_t             pressure_trend;
        logic [15:0]        barometer_raw;
        logic signed [15:0] inside_temp_raw;
        logic [7:0]         inside_humidity;
        logic signed [15:0] outside_temp_raw;
        logic [7:0]         wind_speed_raw;
        logic [15:0]        wind_direction_raw;
        logic signed [15:0] dew_point_raw;
        logic [7:0]         outside_humidity;
        logic [15:0]        rain_rate_raw;
        logic [7:0]         uv_index_raw;
    } result_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_t;

    // crc-16/xmodem, one byte msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic trend_t decode_trend(input logic [7:0] t);
        trend_t r;
        case (t)
            TREND_CODE_FALL_FAST: r = TREND_FALL_FAST;
            TREND_CODE_FALL_SLOW: r = TREND_FALL_SLOW;
            TREND_CODE_STEADY:    r = TREND_STEADY;
            TREND_CODE_RISE_SLOW: r = TREND_RISE_SLOW;
            TREND_CODE_RISE_FAST: r = TREND_RISE_FAST;
            default:              r = TREND_UNKNOWN;
        endcase
        return r;
    endfunction

    // frame position to capture store slot
    function automatic slot_t capture_slot(input logic [COUNT_W-1:0] pos);
        slot_t s;
        s.hit = 1'b1;
        case (pos) inside
            [7'd8:7'd18]:  s.idx = SLOT_W'(pos - 7'd8);
            [7'd31:7'd34]: s.idx = SLOT_W'(pos - 7'd20);
            [7'd42:7'd44]: s.idx = SLOT_W'(pos - 7'd27);
            default:
            begin
                s.hit = 1'b0;
                s.idx = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/lpr_frame_core.sv =====
// frame tracker: byte position, running crc, field capture and result assembly
module lpr_frame_core #(
    parameter int FRAME_BYTES = 100
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        byte_in,
    input  logic              step,
    output logic              emit,
    output lpr_pkg::result_t  result
);

    localparam logic [lpr_pkg::COUNT_W-1:0] LAST_POS = lpr_pkg::COUNT_W'(FRAME_BYTES - 1);

    logic [lpr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [15:0]                 crc_reg, crc_next;
    logic [7:0]                  trend_reg;
    logic [7:0]                  cap_reg [lpr_pkg::NUM_CAPT];
    logic [15:0]                 crc_upd;
    lpr_pkg::slot_t              slot;
    logic                        at_start;
    logic                        no_ack;
    logic                        at_last;

    assign at_start = (count_reg == '0);
    assign no_ack   = at_start && (byte_in != lpr_pkg::ACK_BYTE);
    assign at_last  = (count_reg == LAST_POS);
    assign crc_upd  = lpr_pkg::crc_byte(crc_reg, byte_in);
    assign slot     = lpr_pkg::capture_slot(count_reg);
    assign emit     = no_ack || (!at_start && at_last);

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (step) begin
            if (at_start) begin
                crc_next   = lpr_pkg::CRC_INIT;
                count_next = no_ack ? '0 : lpr_pkg::COUNT_W'(1);
            end else if (at_last) begin
                crc_next   = lpr_pkg::CRC_INIT;
                count_next = '0;
            end else begin
                crc_next   = crc_upd;
                count_next = count_reg + lpr_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            crc_reg   <= lpr_pkg::CRC_INIT;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // capture store, no reset: every entry is rewritten each frame
    always_ff @(posedge clk)
    begin
        if (step && !at_start) begin
            if (count_reg == lpr_pkg::TREND_POS)
                trend_reg <= byte_in;
            if (slot.hit)
                cap_reg[slot.idx] <= byte_in;
        end
    end

    always_comb
    begin
        result = '0;
        if (no_ack) begin
            result.status = lpr_pkg::STATUS_NO_ACK;
        end else begin
            result.status = (crc_upd == 16'h0000) ? lpr_pkg::STATUS_OK
                                                  : lpr_pkg::STATUS_CRC_ERR;
            result.pressure_trend     = lpr_pkg::decode_trend(trend_reg);
            result.barometer_raw      = {cap_reg[1], cap_reg[0]};
            result.inside_temp_raw    = {cap_reg[3], cap_reg[2]};
            result.inside_humidity    = cap_reg[4];
            result.outside_temp_raw   = {cap_reg[6], cap_reg[5]};
            result.wind_speed_raw     = cap_reg[7];
            result.wind_direction_raw = {cap_reg[10], cap_reg[9]};
            result.dew_point_raw      = {cap_reg[12], cap_reg[11]};
            result.outside_humidity   = cap_reg[14];
            result.rain_rate_raw      = {cap_reg[16], cap_reg[15]};
            result.uv_index_raw       = cap_reg[17];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_POS)
        else $error("byte position past frame end");

    a_no_ack_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && at_start && byte_in != lpr_pkg::ACK_BYTE) |->
            (emit && result.status == lpr_pkg::STATUS_NO_ACK))
        else $error("missing ack gave no no-ack result");

    a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (count_reg == '0 && crc_reg == lpr_pkg::CRC_INIT))
        else $error("frame did not restart after result");

    a_ack_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step && at_start && byte_in == lpr_pkg::ACK_BYTE) |=>
            (count_reg == lpr_pkg::COUNT_W'(1)))
        else $error("ack did not start frame");
`endif

endmodule

// ===== hdl/loop_packet_receiver_crc16.sv =====
// top level of the loop packet receiver with crc-16/xmodem check
// the last byte passes the input stage, then its result is held in the output stage
// throughput: one byte per cycle when not stalled; the crc update is combinational
// stalls: only a held result with out_ready low backs up into in_ready
// reset: rst_n async active low clears byte position, crc and both valid flags
module loop_packet_receiver_crc16 #(
    parameter int FRAME_BYTES = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [2:0]         pressure_trend,
    output logic [15:0]        barometer_raw,
    output logic signed [15:0] inside_temp_raw,
    output logic [7:0]         inside_humidity,
    output logic signed [15:0] outside_temp_raw,
    output logic [7:0]         wind_speed_raw,
    output logic [15:0]        wind_direction_raw,
    output logic signed [15:0] dew_point_raw,
    output logic [7:0]         outside_humidity,
    output logic [15:0]        rain_rate_raw,
    output logic [7:0]         uv_index_raw
);

    // input stage: one received byte waiting to be processed
    logic             stage_valid_reg, stage_valid_next;
    logic [7:0]       stage_byte_reg;

    // output stage: one finished result waiting to be taken
    logic             out_valid_reg, out_valid_next;
    lpr_pkg::result_t out_res_reg;

    logic             emit;
    lpr_pkg::result_t result;
    logic             out_space;
    logic             advance;

    // a byte moves on when it makes no result or the result slot is free
    assign out_space = !out_valid_reg || out_ready;
    assign advance   = stage_valid_reg && (!emit || out_space);
    assign in_ready  = !stage_valid_reg || advance;

    lpr_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (stage_byte_reg),
        .step    (advance),
        .emit    (emit),
        .result  (result)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_ready)
            stage_valid_next = in_valid;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_space)
            out_valid_next = advance && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_byte_reg <= rx_byte;
        if (out_space && advance && emit)
            out_res_reg <= result;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_res_reg.status;
    assign pressure_trend     = out_res_reg.pressure_trend;
    assign barometer_raw      = out_res_reg.barometer_raw;
    assign inside_temp_raw    = out_res_reg.inside_temp_raw;
    assign inside_humidity    = out_res_reg.inside_humidity;
    assign outside_temp_raw   = out_res_reg.outside_temp_raw;
    assign wind_speed_raw     = out_res_reg.wind_speed_raw;
    assign wind_direction_raw = out_res_reg.wind_direction_raw;
    assign dew_point_raw      = out_res_reg.dew_point_raw;
    assign outside_humidity   = out_res_reg.outside_humidity;
    assign rain_rate_raw      = out_res_reg.rain_rate_raw;
    assign uv_index_raw       = out_res_reg.uv_index_raw;

endmodule
